@@ design/pamc_pkg.sv @@
// Shared types, constants and the arctangent table of the point-approach controller.
`timescale 1ns / 1ps
package pamc_pkg;

   // Build options
   localparam int SHAKE_ENABLE = 0;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_MAX   = 24;
   localparam int CORDIC_ITERS = (ANGLE_BITS < CORDIC_MAX) ? ANGLE_BITS : CORDIC_MAX;
   localparam int ITER_W       = $clog2(CORDIC_MAX);

   // Serial multiplier: signed multiplicand, unsigned multiplier, one bit a cycle
   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // CORDIC datapath
   localparam int CD_W = 52;
   localparam int CZ_W = 34;

   localparam logic [MUL_B_W-1:0] INV_GAIN_Q16 = 32'd39797;
   localparam logic [MUL_B_W-1:0] PI_Q29       = 32'd1686629713;

   // Register indexes
   localparam logic [2:0] CSR_REACH    = 3'd0;
   localparam logic [2:0] CSR_END_TOL  = 3'd1;
   localparam logic [2:0] CSR_ANG_TOL  = 3'd2;
   localparam logic [2:0] CSR_ATT_GAIN = 3'd3;
   localparam logic [2:0] CSR_ROT_GAIN = 3'd4;
   localparam logic [2:0] CSR_ANG_LIM  = 3'd5;
   localparam logic [2:0] CSR_LIN_LIM  = 3'd6;
   localparam logic [2:0] CSR_RET_LIM  = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ORIENT = 3'd1,
      PH_SMASH  = 3'd2,
      PH_LEFT   = 3'd3,
      PH_RIGHT  = 3'd4,
      PH_REGOAL = 3'd5,
      PH_HOME   = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      STS_IDLE  = 2'd0,
      STS_RUN   = 2'd1,
      STS_DONE  = 2'd2,
      STS_ABORT = 2'd3
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] cmd_vx;
      logic signed [15:0] cmd_vy;
      logic signed [15:0] cmd_wz;
      phase_type          phase;
      status_type         status;
   } rsp_word_type;

   typedef struct packed {
      logic                      go;
      logic signed [MUL_A_W-1:0] a;
      logic        [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                   go;
      logic                   rotate;
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
      logic        [31:0]     angle;
   } cordic_req_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ design/point_approach_motion_controller_top.sv @@
// Top level of the point-approach controller: registers, phase sequencer, output word.
// Each word is worked through the shared bit-serial multiplier (one pass per product)
//   and, for a pose tick, the iterative CORDIC.
// Throughput: one word in flight; the next is taken once the result is registered.
// Reset: synchronous, active high; phase goes idle, registers take their defaults.
`timescale 1ns / 1ps
module point_approach_motion_controller_top import pamc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,      // pick the work for the current phase
      ST_DIST_AX,   // |dx|^2
      ST_DIST_AY,   // + |dy|^2
      ST_DIST_LIM,  // against limit^2
      ST_DIST_CMP,  // branch on distance result
      ST_VEC,       // goal bearing
      ST_TURN_GAIN, // gain * heading error
      ST_TURN_PI,   // * pi
      ST_ATT_X,     // gain * dx
      ST_ATT_Y,     // gain * dy
      ST_ATT_ROT,   // rotate into robot frame
      ST_ATT_SX,    // gain compensation, x
      ST_ATT_SY,    // gain compensation, y
      ST_OUT
   } state_type;

   // Configuration registers
   logic [30:0] reach_ff, endtol_ff;
   logic [14:0] angtol_ff, anglim_ff, linlim_ff, retlim_ff;
   logic [15:0] attgain_ff, rotgain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff   <= 31'd113377;
         endtol_ff  <= 31'd3932;
         angtol_ff  <= 15'd2086;
         attgain_ff <= 16'd6554;
         rotgain_ff <= 16'd2048;
         anglim_ff  <= 15'd1229;
         linlim_ff  <= 15'd1229;
         retlim_ff  <= 15'd819;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REACH:    reach_ff   <= csr_wdata;
            CSR_END_TOL:  endtol_ff  <= csr_wdata;
            CSR_ANG_TOL:  angtol_ff  <= csr_wdata[14:0];
            CSR_ATT_GAIN: attgain_ff <= csr_wdata[15:0];
            CSR_ROT_GAIN: rotgain_ff <= csr_wdata[15:0];
            CSR_ANG_LIM:  anglim_ff  <= csr_wdata[14:0];
            CSR_LIN_LIM:  linlim_ff  <= csr_wdata[14:0];
            CSR_RET_LIM:  retlim_ff  <= csr_wdata[14:0];
            default:      ;
         endcase
      end
   end

   // Sequencer state
   state_type          state_ff;
   logic               pend_ff;     // unit request issued, waiting for done
   logic               start_ff;    // current word is a start
   phase_type          ph_ff;       // motion phase
   logic signed [31:0] px_ff, py_ff;
   logic [15:0]        hd_ff;
   logic signed [31:0] goal_x_ff, goal_y_ff, home_x_ff, home_y_ff;
   logic signed [31:0] strike_x_ff, strike_y_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [31:0]        lim_ff;
   logic [64:0]        sq_ff;
   logic               gt_ff, lt_ff;
   logic signed [15:0] err_ff;
   logic signed [47:0] tmp_ff;
   logic signed [CD_W-1:0] cx_ff, cy_ff;
   logic [14:0]        att_lim_ff;
   logic [15:0]        res_vx_ff, res_vy_ff, res_wz_ff;
   phase_type          out_ph_ff;
   status_type         out_st_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   // Shared units
   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] mul_prod;
   logic                      mul_done;
   cordic_req_type            cd_req;
   logic signed [CD_W-1:0]    cd_x, cd_y;
   logic [31:0]               cd_z;
   logic                      cd_done;

   pamc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .prod    (mul_prod),
      .done    (mul_done)
   );

   pamc_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cd_req (cd_req),
      .cd_x   (cd_x),
      .cd_y   (cd_y),
      .cd_z   (cd_z),
      .done   (cd_done)
   );

   function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return {a[31], a} - {b[31], b};
   endfunction

   function automatic logic [31:0] abs33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   // Symmetric saturation to +/- lim
   function automatic logic [15:0] sat16(input logic signed [63:0] v, input logic [14:0] lim);
      logic signed [63:0] hi, lo;
      hi = {49'd0, lim};
      lo = -hi;
      if (v > hi) begin
         return hi[15:0];
      end else if (v < lo) begin
         return lo[15:0];
      end
      return v[15:0];
   endfunction

   // Operand selection for the units
   logic [31:0]               ax_now, ay_now;
   logic [31:0]               bear_sum;
   logic [15:0]               err_now;
   logic [16:0]               err_abs;
   logic                      err_big;
   logic signed [MUL_P_W-1:0] prod_sh44, prod_sh24;
   logic [31:0]               neg_hd;
   logic [15:0]               lin_neg;

   always_comb begin
      ax_now    = abs33(dx_ff);
      ay_now    = abs33(dy_ff);
      // bearing rounded to 16 bits, error wrapped to a half turn
      bear_sum  = cd_z + 32'h0000_8000;
      err_now   = bear_sum[31:16] - hd_ff;
      err_abs   = err_now[15] ? (17'd0 - {err_now[15], err_now}) : {1'b0, err_now};
      err_big   = err_abs > {2'b00, angtol_ff};
      prod_sh44 = mul_prod >>> 44;
      prod_sh24 = mul_prod >>> 24;
      neg_hd    = 32'd0 - {hd_ff, 16'd0};
      lin_neg   = 16'd0 - {1'b0, linlim_ff};

      mul_req.go = !pend_ff;
      mul_req.a  = '0;
      mul_req.b  = '0;
      unique case (state_ff)
         ST_DIST_AX: begin
            mul_req.a = {16'd0, ax_now};
            mul_req.b = ax_now;
         end
         ST_DIST_AY: begin
            mul_req.a = {16'd0, ay_now};
            mul_req.b = ay_now;
         end
         ST_DIST_LIM: begin
            mul_req.a = {16'd0, lim_ff};
            mul_req.b = lim_ff;
         end
         ST_TURN_GAIN: begin
            mul_req.a = {{32{err_ff[15]}}, err_ff};
            mul_req.b = {16'd0, rotgain_ff};
         end
         ST_TURN_PI: begin
            mul_req.a = tmp_ff;
            mul_req.b = PI_Q29;
         end
         ST_ATT_X: begin
            mul_req.a = {{15{dx_ff[32]}}, dx_ff};
            mul_req.b = {16'd0, attgain_ff};
         end
         ST_ATT_Y: begin
            mul_req.a = {{15{dy_ff[32]}}, dy_ff};
            mul_req.b = {16'd0, attgain_ff};
         end
         ST_ATT_SX: begin
            mul_req.a = cd_x[MUL_A_W-1:0];
            mul_req.b = INV_GAIN_Q16;
         end
         ST_ATT_SY: begin
            mul_req.a = cd_y[MUL_A_W-1:0];
            mul_req.b = INV_GAIN_Q16;
         end
         default: mul_req.go = 1'b0;
      endcase

      cd_req.go     = !pend_ff && (state_ff == ST_VEC || state_ff == ST_ATT_ROT);
      cd_req.rotate = (state_ff == ST_ATT_ROT);
      if (state_ff == ST_ATT_ROT) begin
         cd_req.x     = cx_ff;
         cd_req.y     = cy_ff;
         cd_req.angle = neg_hd;
      end else begin
         // position difference scaled by 65536
         cd_req.x     = {{(CD_W-49){dx_ff[32]}}, dx_ff, 16'd0};
         cd_req.y     = {{(CD_W-49){dy_ff[32]}}, dy_ff, 16'd0};
         cd_req.angle = 32'd0;
      end
   end

   // Phase sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         ph_ff        <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output slot is refilled from ST_OUT below
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_done || cd_done) begin
            pend_ff <= 1'b0;
         end else if (mul_req.go || cd_req.go) begin
            pend_ff <= 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  px_ff     <= req_data.pose_x;
                  py_ff     <= req_data.pose_y;
                  hd_ff     <= req_data.pose_heading;
                  start_ff  <= !req_data.req_type;
                  res_vx_ff <= '0;
                  res_vy_ff <= '0;
                  res_wz_ff <= '0;
                  if (!req_data.req_type) begin
                     // start: latch goal and home, check reach
                     goal_x_ff <= req_data.target_x;
                     goal_y_ff <= req_data.target_y;
                     home_x_ff <= req_data.pose_x;
                     home_y_ff <= req_data.pose_y;
                     dx_ff     <= diff33(req_data.target_x, req_data.pose_x);
                     dy_ff     <= diff33(req_data.target_y, req_data.pose_y);
                     lim_ff    <= {1'b0, reach_ff};
                     state_ff  <= ST_DIST_AX;
                  end else begin
                     state_ff  <= ST_EVAL;
                  end
               end
            end

            ST_EVAL: begin
               // right uses twice the tolerance
               lim_ff <= (ph_ff == PH_RIGHT) ? {endtol_ff, 1'b0} : {1'b0, endtol_ff};
               unique case (ph_ff)
                  PH_ORIENT: begin
                     dx_ff    <= diff33(goal_x_ff, px_ff);
                     dy_ff    <= diff33(goal_y_ff, py_ff);
                     state_ff <= ST_VEC;
                  end
                  PH_SMASH, PH_REGOAL: begin
                     dx_ff    <= diff33(goal_x_ff, px_ff);
                     dy_ff    <= diff33(goal_y_ff, py_ff);
                     state_ff <= ST_DIST_AX;
                  end
                  PH_LEFT: begin
                     dx_ff    <= diff33(px_ff, strike_x_ff);
                     dy_ff    <= diff33(py_ff, strike_y_ff);
                     state_ff <= ST_DIST_AX;
                  end
                  PH_RIGHT: begin
                     dx_ff    <= diff33(px_ff, strike_x_ff);
                     dy_ff    <= diff33(py_ff, strike_y_ff);
                     state_ff <= ST_DIST_AX;
                  end
                  PH_HOME: begin
                     dx_ff    <= diff33(home_x_ff, px_ff);
                     dy_ff    <= diff33(home_y_ff, py_ff);
                     state_ff <= ST_DIST_AX;
                  end
                  default: begin
                     // tick while idle
                     ph_ff     <= PH_IDLE;
                     out_ph_ff <= PH_IDLE;
                     out_st_ff <= STS_IDLE;
                     state_ff  <= ST_OUT;
                  end
               endcase
            end

            ST_DIST_AX: begin
               if (pend_ff && mul_done) begin
                  sq_ff    <= {1'b0, mul_prod[63:0]};
                  state_ff <= ST_DIST_AY;
               end
            end

            ST_DIST_AY: begin
               if (pend_ff && mul_done) begin
                  sq_ff    <= {1'b0, sq_ff[63:0]} + {1'b0, mul_prod[63:0]};
                  state_ff <= ST_DIST_LIM;
               end
            end

            ST_DIST_LIM: begin
               if (pend_ff && mul_done) begin
                  gt_ff    <= sq_ff > {1'b0, mul_prod[63:0]};
                  lt_ff    <= sq_ff < {1'b0, mul_prod[63:0]};
                  state_ff <= ST_DIST_CMP;
               end
            end

            ST_DIST_CMP: begin
               if (start_ff) begin
                  out_ph_ff <= gt_ff ? PH_IDLE : PH_ORIENT;
                  out_st_ff <= gt_ff ? STS_ABORT : STS_RUN;
                  ph_ff     <= gt_ff ? PH_IDLE : PH_ORIENT;
                  state_ff  <= ST_OUT;
               end else begin
                  unique case (ph_ff)
                     PH_SMASH: begin
                        if (gt_ff) begin
                           att_lim_ff <= linlim_ff;
                           state_ff   <= ST_ATT_X;
                        end else begin
                           strike_x_ff <= px_ff;
                           strike_y_ff <= py_ff;
                           ph_ff       <= (SHAKE_ENABLE != 0) ? PH_LEFT : PH_HOME;
                           state_ff    <= ST_EVAL;
                        end
                     end
                     PH_LEFT: begin
                        if (lt_ff) begin
                           res_vy_ff <= {1'b0, linlim_ff};
                           out_ph_ff <= PH_LEFT;
                           out_st_ff <= STS_RUN;
                           state_ff  <= ST_OUT;
                        end else begin
                           ph_ff    <= PH_RIGHT;
                           state_ff <= ST_EVAL;
                        end
                     end
                     PH_RIGHT: begin
                        if (lt_ff) begin
                           res_vy_ff <= lin_neg;
                           out_ph_ff <= PH_RIGHT;
                           out_st_ff <= STS_RUN;
                           state_ff  <= ST_OUT;
                        end else begin
                           ph_ff    <= PH_REGOAL;
                           state_ff <= ST_EVAL;
                        end
                     end
                     PH_REGOAL: begin
                        if (gt_ff) begin
                           att_lim_ff <= linlim_ff;
                           state_ff   <= ST_ATT_X;
                        end else begin
                           ph_ff    <= PH_HOME;
                           state_ff <= ST_EVAL;
                        end
                     end
                     PH_HOME: begin
                        if (gt_ff) begin
                           att_lim_ff <= retlim_ff;
                           state_ff   <= ST_ATT_X;
                        end else begin
                           // home reached: report success, go idle
                           ph_ff     <= PH_IDLE;
                           out_ph_ff <= PH_DONE;
                           out_st_ff <= STS_DONE;
                           state_ff  <= ST_OUT;
                        end
                     end
                     default: state_ff <= ST_EVAL;
                  endcase
               end
            end

            ST_VEC: begin
               if (pend_ff && cd_done) begin
                  err_ff <= err_now;
                  if (ph_ff == PH_ORIENT && !err_big) begin
                     ph_ff    <= PH_SMASH;
                     state_ff <= ST_EVAL;
                  end else begin
                     state_ff <= ST_TURN_GAIN;
                  end
               end
            end

            ST_TURN_GAIN: begin
               if (pend_ff && mul_done) begin
                  tmp_ff   <= mul_prod[47:0];
                  state_ff <= ST_TURN_PI;
               end
            end

            ST_TURN_PI: begin
               if (pend_ff && mul_done) begin
                  res_wz_ff <= sat16(prod_sh44[63:0], anglim_ff);
                  out_ph_ff <= ph_ff;
                  out_st_ff <= STS_RUN;
                  state_ff  <= ST_OUT;
               end
            end

            ST_ATT_X: begin
               if (pend_ff && mul_done) begin
                  cx_ff    <= mul_prod[CD_W+7:8];
                  state_ff <= ST_ATT_Y;
               end
            end

            ST_ATT_Y: begin
               if (pend_ff && mul_done) begin
                  cy_ff    <= mul_prod[CD_W+7:8];
                  state_ff <= ST_ATT_ROT;
               end
            end

            ST_ATT_ROT: begin
               if (pend_ff && cd_done) begin
                  state_ff <= ST_ATT_SX;
               end
            end

            ST_ATT_SX: begin
               if (pend_ff && mul_done) begin
                  res_vx_ff <= sat16(prod_sh24[63:0], att_lim_ff);
                  state_ff  <= ST_ATT_SY;
               end
            end

            ST_ATT_SY: begin
               if (pend_ff && mul_done) begin
                  res_vy_ff <= sat16(prod_sh24[63:0], att_lim_ff);
                  if (ph_ff == PH_SMASH) begin
                     // smash adds the heading term on the same pose
                     state_ff <= ST_VEC;
                  end else begin
                     out_ph_ff <= ph_ff;
                     out_st_ff <= STS_RUN;
                     state_ff  <= ST_OUT;
                  end
               end
            end

            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.cmd_vx <= res_vx_ff;
                  rsp_data_ff.cmd_vy <= res_vy_ff;
                  rsp_data_ff.cmd_wz <= res_wz_ff;
                  rsp_data_ff.phase  <= out_ph_ff;
                  rsp_data_ff.status <= out_st_ff;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted word always keeps the sequencer busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer not busy after accepting a word");

   // Running words carry an active phase
   a_run_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STS_RUN) |->
      (rsp_data.phase != PH_IDLE && rsp_data.phase != PH_DONE))
      else $error("running status with inactive phase");

   // Done phase only with success
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.phase == PH_DONE) |-> (rsp_data.status == STS_DONE))
      else $error("done phase without success status");

   // Idle and aborted words carry a zero command
   a_zero_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STS_IDLE || rsp_data.status == STS_ABORT)) |->
      (rsp_data.cmd_vx == 16'sd0 && rsp_data.cmd_vy == 16'sd0 && rsp_data.cmd_wz == 16'sd0))
      else $error("non-zero command on idle or aborted word");

endmodule

@@ design/pamc_serial_mul.sv @@
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
`timescale 1ns / 1ps
module pamc_serial_mul import pamc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mul_req_type               mul_req,
   output logic signed [MUL_P_W-1:0] prod,
   output logic                      done
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic signed [MUL_P_W-1:0] mcand_ff;
   logic [MUL_B_W-1:0]        mplier_ff;
   logic signed [MUL_P_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.go) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= '0;
            mcand_ff  <= {{(MUL_P_W-MUL_A_W){mul_req.a[MUL_A_W-1]}}, mul_req.a};
            mplier_ff <= mul_req.b;
            acc_ff    <= '0;
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff <<< 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_B_W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

@@ design/pamc_cordic.sv @@
// Iterative CORDIC, one micro-rotation a cycle, vectoring or rotation mode.
`timescale 1ns / 1ps
module pamc_cordic import pamc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cordic_req_type         cd_req,
   output logic signed [CD_W-1:0] cd_x,
   output logic signed [CD_W-1:0] cd_y,
   output logic [31:0]            cd_z,
   output logic                   done
);

   logic                   busy_ff;
   logic                   done_ff;
   logic                   rotate_ff;
   logic [ITER_W-1:0]      iter_ff;
   logic signed [CD_W-1:0] x_ff, y_ff;
   logic signed [CZ_W-1:0] z_ff;

   logic signed [CD_W-1:0] x0, y0, xs, ys;
   logic signed [CZ_W-1:0] z0, at;
   logic [31:0]            flip_sum, ang_flip;
   logic                   cw;

   // Pre-flip into the right half plane
   always_comb begin
      flip_sum = cd_req.angle + 32'h4000_0000;
      ang_flip = cd_req.angle + 32'h8000_0000;
      x0 = cd_req.x;
      y0 = cd_req.y;
      z0 = '0;
      if (cd_req.rotate) begin
         if (flip_sum[31]) begin
            x0 = -cd_req.x;
            y0 = -cd_req.y;
            z0 = {{(CZ_W-32){ang_flip[31]}}, ang_flip};
         end else begin
            z0 = {{(CZ_W-32){cd_req.angle[31]}}, cd_req.angle};
         end
      end else if (cd_req.x[CD_W-1]) begin
         x0 = -cd_req.x;
         y0 = -cd_req.y;
         z0 = CZ_W'(33'h0_8000_0000);
      end
   end

   always_comb begin
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = {{(CZ_W-32){1'b0}}, atan_entry(iter_ff)};
      cw = rotate_ff ? z_ff[CZ_W-1] : !y_ff[CD_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cd_req.go) begin
            busy_ff   <= 1'b1;
            rotate_ff <= cd_req.rotate;
            iter_ff   <= '0;
            x_ff      <= x0;
            y_ff      <= y0;
            z_ff      <= z0;
         end else if (busy_ff) begin
            if (cw) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_ITERS-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign cd_x = x_ff;
   assign cd_y = y_ff;
   assign cd_z = z_ff[31:0];
   assign done = done_ff;

endmodule

@@ dv/tb_point_approach_motion_controller_top.sv @@
// Self-checking testbench of the point-approach motion controller top level.
`timescale 1ns / 1ps
module tb_point_approach_motion_controller_top;
   import pamc_pkg::*;

   // Watchdog: cycles with no handshake on either side before giving up.
   // The limit covers the worst word plus receiver stalls and the long hold-off.
   // The hold-off outlasts two worst-case words so the block surely fills.
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLDOFF_LEN  = 1000;
   localparam int SETTLE_LEN   = 500;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = CSR_REACH;
   logic [30:0]  csr_wdata = '0;

   point_approach_motion_controller_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: registers and the mission the block is flying
   // ---------------------------------------------------------------------
   logic [30:0] lim_reach, tol_end;
   logic [14:0] tol_angle, lim_ang, lim_lin, lim_ret;
   logic [15:0] gain_att, gain_rot;
   phase_type   plan_phase;
   longint      goal_px, goal_py, home_px, home_py, strike_px, strike_py;

   rsp_word_type cmd_expect_q[$];
   int           err_count = 0;
   int           words_in = 0;
   int           words_out = 0;
   int           aborts_seen = 0;
   int           dones_seen = 0;

   // Stimulus shaping flags
   bit quiet_run = 1'b0;   // no idling on either side
   bit hold_req  = 1'b0;   // ask the receiver to hold off

   // atan(2^-i) in 32-bit binary angle
   localparam logic [31:0] ARC_TAB [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // sign of dx^2 + dy^2 - lim^2, exact
   function automatic int span_cmp(longint dx, longint dy, longint lim);
      longint      ax, ay;
      logic [67:0] s, l;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax > lim || ay > lim) return 1;
      s = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
      l = 68'(lim) * 68'(lim);
      return (s > l) ? 1 : ((s == l) ? 0 : -1);
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // vectoring CORDIC: bearing of (dx, dy) as a 16-bit binary angle
   function automatic logic [15:0] goal_bearing(longint dx, longint dy);
      longint      x, y, nx;
      logic [31:0] z, zr;
      x = dx * 65536;
      y = dy * 65536;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ARC_TAB[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ARC_TAB[i];
         end
         x = nx;
      end
      zr = z + 32'h8000;
      return zr[31:16];
   endfunction

   function automatic int aim_error(longint dx, longint dy, logic [15:0] hd);
      logic [15:0] e;
      e = goal_bearing(dx, dy) - hd;
      return int'(signed'(e));
   endfunction

   function automatic longint turn_rate(int err);
      longint w;
      w = (longint'(gain_rot) * longint'(err) * longint'(PI_Q29)) >>> 44;
      return clamp(w, longint'(lim_ang));
   endfunction

   // proportional pull, rotated into the robot frame by a rotation CORDIC
   function automatic void pull_toward(longint dx, longint dy, logic [15:0] hd,
                                       longint lim, output longint vx,
                                       output longint vy);
      longint      x, y, z, nx;
      logic [31:0] a, q;
      x = (longint'(gain_att) * dx) >>> 8;
      y = (longint'(gain_att) * dy) >>> 8;
      a = 32'd0 - {hd, 16'd0};
      q = a + 32'h4000_0000;
      if (q[31]) begin
         x = -x;
         y = -y;
         a = a + 32'h8000_0000;
      end
      z = longint'(signed'(a));
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ARC_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ARC_TAB[i]);
         end
         x = nx;
      end
      vx = clamp((x * longint'(INV_GAIN_Q16)) >>> 24, lim);
      vy = clamp((y * longint'(INV_GAIN_Q16)) >>> 24, lim);
   endfunction

   function automatic rsp_word_type make_cmd(longint vx, longint vy, longint wz,
                                             phase_type ph, status_type st);
      rsp_word_type r;
      r.cmd_vx = vx[15:0];
      r.cmd_vy = vy[15:0];
      r.cmd_wz = wz[15:0];
      r.phase  = ph;
      r.status = st;
      return r;
   endfunction

   // Advances the mission by one word and returns the command it yields
   function automatic rsp_word_type next_command(req_word_type w);
      longint px, py, vx, vy;
      int     err;
      px = longint'(w.pose_x);
      py = longint'(w.pose_y);
      if (w.req_type == 1'b0) begin
         goal_px = longint'(w.target_x);
         goal_py = longint'(w.target_y);
         home_px = px;
         home_py = py;
         if (span_cmp(goal_px - px, goal_py - py, longint'(lim_reach)) > 0) begin
            plan_phase = PH_IDLE;
            return make_cmd(0, 0, 0, PH_IDLE, STS_ABORT);
         end
         plan_phase = PH_ORIENT;
         return make_cmd(0, 0, 0, PH_ORIENT, STS_RUN);
      end
      // finished phases fall through on the same pose
      forever begin
         case (plan_phase)
            PH_ORIENT: begin
               err = aim_error(goal_px - px, goal_py - py, w.pose_heading);
               if (((err < 0) ? -err : err) > int'(tol_angle))
                  return make_cmd(0, 0, turn_rate(err), PH_ORIENT, STS_RUN);
               plan_phase = PH_SMASH;
            end
            PH_SMASH: begin
               if (span_cmp(goal_px - px, goal_py - py, longint'(tol_end)) > 0) begin
                  pull_toward(goal_px - px, goal_py - py, w.pose_heading,
                              longint'(lim_lin), vx, vy);
                  err = aim_error(goal_px - px, goal_py - py, w.pose_heading);
                  return make_cmd(vx, vy, turn_rate(err), PH_SMASH, STS_RUN);
               end
               strike_px = px;
               strike_py = py;
               plan_phase = (SHAKE_ENABLE != 0) ? PH_LEFT : PH_HOME;
            end
            PH_LEFT: begin
               if (span_cmp(px - strike_px, py - strike_py, longint'(tol_end)) < 0)
                  return make_cmd(0, longint'(lim_lin), 0, PH_LEFT, STS_RUN);
               plan_phase = PH_RIGHT;
            end
            PH_RIGHT: begin
               if (span_cmp(px - strike_px, py - strike_py, 2 * longint'(tol_end)) < 0)
                  return make_cmd(0, -longint'(lim_lin), 0, PH_RIGHT, STS_RUN);
               plan_phase = PH_REGOAL;
            end
            PH_REGOAL: begin
               if (span_cmp(goal_px - px, goal_py - py, longint'(tol_end)) > 0) begin
                  pull_toward(goal_px - px, goal_py - py, w.pose_heading,
                              longint'(lim_lin), vx, vy);
                  return make_cmd(vx, vy, 0, PH_REGOAL, STS_RUN);
               end
               plan_phase = PH_HOME;
            end
            PH_HOME: begin
               if (span_cmp(home_px - px, home_py - py, longint'(tol_end)) > 0) begin
                  pull_toward(home_px - px, home_py - py, w.pose_heading,
                              longint'(lim_ret), vx, vy);
                  return make_cmd(vx, vy, 0, PH_HOME, STS_RUN);
               end
               plan_phase = PH_IDLE;
               return make_cmd(0, 0, 0, PH_DONE, STS_DONE);
            end
            default: begin
               plan_phase = PH_IDLE;
               return make_cmd(0, 0, 0, PH_IDLE, STS_IDLE);
            end
         endcase
      end
   endfunction

   function automatic void load_defaults();
      lim_reach = 31'd113377;
      tol_end   = 31'd3932;
      tol_angle = 15'd2086;
      gain_att  = 16'd6554;
      gain_rot  = 16'd2048;
      lim_ang   = 15'd1229;
      lim_lin   = 15'd1229;
      lim_ret   = 15'd819;
      plan_phase = PH_IDLE;
      goal_px = 0; goal_py = 0; home_px = 0; home_py = 0;
      strike_px = 0; strike_py = 0;
   endfunction

   // ---------------------------------------------------------------------
   // Monitors: input words feed the predictor, output words are checked
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH word %0d %s: got %0d expected %0d", words_out, field, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         cmd_expect_q.push_back(next_command(req_data));
         words_in++;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cmd_expect_q.size() == 0) begin
            report_mismatch("word with nothing outstanding", 1, 0);
         end else begin
            want = cmd_expect_q.pop_front();
            if (rsp_data.cmd_vx !== want.cmd_vx)
               report_mismatch("cmd_vx", rsp_data.cmd_vx, want.cmd_vx);
            if (rsp_data.cmd_vy !== want.cmd_vy)
               report_mismatch("cmd_vy", rsp_data.cmd_vy, want.cmd_vy);
            if (rsp_data.cmd_wz !== want.cmd_wz)
               report_mismatch("cmd_wz", rsp_data.cmd_wz, want.cmd_wz);
            if (rsp_data.phase !== want.phase)
               report_mismatch("phase", rsp_data.phase, want.phase);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (want.status == STS_ABORT) aborts_seen++;
            if (want.status == STS_DONE) dones_seen++;
         end
         words_out++;
      end
   end

   // Receiver: random stall, quiet stretches, and a counted long hold-off
   always @(negedge clock) begin
      int hold_cnt;
      if (hold_req) begin
         rsp_stall <= 1'b1;
         for (hold_cnt = 0; hold_cnt < HOLDOFF_LEN; hold_cnt++) @(negedge clock);
         hold_req = 1'b0;
      end
      rsp_stall <= quiet_run ? 1'b0 : ($urandom_range(99) < 23);
   end

   // Watchdog: no handshake for too long means the block has hung
   always @(posedge clock) begin
      int idle_cnt;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cnt = 0;
      else
         idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("tb_point_approach_motion_controller_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------------
   // Sends one word; returns at the accepting edge with valid still high
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while (!quiet_run && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Sender pause until every outstanding command is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (cmd_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_REACH:    lim_reach = val;
         CSR_END_TOL:  tol_end   = val;
         CSR_ANG_TOL:  tol_angle = val[14:0];
         CSR_ATT_GAIN: gain_att  = val[15:0];
         CSR_ROT_GAIN: gain_rot  = val[15:0];
         CSR_ANG_LIM:  lim_ang   = val[14:0];
         CSR_LIN_LIM:  lim_lin   = val[14:0];
         CSR_RET_LIM:  lim_ret   = val[14:0];
         default:      ;
      endcase
   endtask

   // all eight registers at once; only called with nothing in flight
   task automatic write_all(logic [30:0] r, logic [30:0] e, logic [30:0] a,
                            logic [30:0] g, logic [30:0] q, logic [30:0] w,
                            logic [30:0] l, logic [30:0] h);
      write_reg(CSR_REACH, r);
      write_reg(CSR_END_TOL, e);
      write_reg(CSR_ANG_TOL, a);
      write_reg(CSR_ATT_GAIN, g);
      write_reg(CSR_ROT_GAIN, q);
      write_reg(CSR_ANG_LIM, w);
      write_reg(CSR_LIN_LIM, l);
      write_reg(CSR_RET_LIM, h);
   endtask

   function automatic req_word_type pose_word(logic kind, longint tx, longint ty,
                                              longint px, longint py,
                                              logic [15:0] hd);
      req_word_type w;
      w.req_type     = kind;
      w.target_x     = tx[31:0];
      w.target_y     = ty[31:0];
      w.pose_x       = px[31:0];
      w.pose_y       = py[31:0];
      w.pose_heading = hd;
      return w;
   endfunction

   function automatic req_word_type noise_word();
      req_word_type w;
      w.req_type     = ($urandom_range(2) != 0);
      w.target_x     = $urandom;
      w.target_y     = $urandom;
      w.pose_x       = $urandom;
      w.pose_y       = $urandom;
      w.pose_heading = 16'($urandom);
      return w;
   endfunction

   // A well-formed mission: start, orient, drive out to the goal and back home.
   // Poses stay inside +/-2^30 so the intermediate points never wrap.
   task automatic fly_mission(int steps);
      longint      hx, hy, dx, dy, px, py, span;
      logic [15:0] aim, hd;
      int          jit;
      span = (lim_reach > 31'd2000000) ? 2000000 : longint'(lim_reach) + 1;
      hx = longint'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
      hy = longint'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
      hx = hx >>> 1;
      hy = hy >>> 1;
      dx = longint'($urandom_range(32'(span))) - span / 2;
      dy = longint'($urandom_range(32'(span))) - span / 2;
      send_word(pose_word(1'b0, hx + dx, hy + dy, hx, hy, 16'($urandom)));
      // up to two ticks with a random heading, mostly turning on the spot
      repeat ($urandom_range(2)) send_word(pose_word(1'b1, $urandom, $urandom, hx, hy,
                                                      16'($urandom)));
      for (int i = 0; i <= 2 * steps; i++) begin
         if (i <= steps) begin
            px = hx + dx * i / steps;
            py = hy + dy * i / steps;
         end else begin
            px = hx + dx * (2 * steps - i) / steps;
            py = hy + dy * (2 * steps - i) / steps;
         end
         aim = goal_bearing(hx + dx - px, hy + dy - py);
         jit = (tol_angle > 1) ? int'($urandom_range(tol_angle / 2)) : 0;
         hd = aim + 16'(jit) - 16'(tol_angle / 4);
         if ($urandom_range(9) == 0) hd = 16'($urandom);
         // ticks carry stray target fields that must be ignored
         send_word(pose_word(1'b1, $urandom, $urandom, px, py, hd));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_corners();
      longint mn, mx;
      mn = -64'sd2147483648;
      mx = 64'sd2147483647;
      // tick while idle, extreme headings
      send_word(pose_word(1'b1, mx, mn, mx, mn, 16'h7FFF));
      send_word(pose_word(1'b1, 0, 0, 0, 0, 16'h8000));
      // far start aborts and leaves the block idle
      send_word(pose_word(1'b0, mx, mx, mn, mn, 16'h0000));
      send_word(pose_word(1'b1, 0, 0, 0, 0, 16'h0000));
      send_word(pose_word(1'b0, mn, mx, mx, mn, 16'hFFFF));
      // goal on the robot
      send_word(pose_word(1'b0, 1234, -5678, 1234, -5678, 16'h0000));
      send_word(pose_word(1'b1, mx, mn, 1234, -5678, 16'h0000));
      // same, but facing away
      send_word(pose_word(1'b0, mn, mn, mn, mn, 16'h0000));
      send_word(pose_word(1'b1, 0, 0, mn, mn, 16'h8000));
      send_word(pose_word(1'b1, 0, 0, mn, mn, 16'h7FFF));
      send_word(pose_word(1'b1, 0, 0, mn, mn, 16'h0001));
      // start while running replaces the action
      send_word(pose_word(1'b0, 100000, 0, 0, 0, 16'h4000));
      send_word(pose_word(1'b0, 0, 100000, 0, 0, 16'h4000));
      send_word(pose_word(1'b1, 0, 0, 0, 0, 16'h4000));
      send_word(pose_word(1'b1, 0, 0, 0, 50000, 16'h4000));
      send_word(pose_word(1'b1, 0, 0, 0, 100000, 16'hC000));
      send_word(pose_word(1'b1, 0, 0, 0, 0, 16'h0000));
      // reach limit boundary: exactly on it passes, one beyond aborts
      send_word(pose_word(1'b0, mx, 0, mx - 113377, 0, 16'h0000));
      send_word(pose_word(1'b0, mn, 0, mn + 113378, 0, 16'h0000));
      drain();
   endtask

   task automatic test_config_extremes();
      // everything at maximum: largest gains, tolerances and limits
      write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF, 31'hFFFF, 31'hFFFF,
                31'h7FFF, 31'h7FFF, 31'h7FFF);
      repeat (6) fly_mission(3);
      repeat (10) send_word(noise_word());
      drain();
      // everything at zero: only exact arrivals finish, all commands clamp to zero
      write_all('0, '0, '0, '0, '0, '0, '0, '0);
      repeat (4) fly_mission(2);
      repeat (10) send_word(noise_word());
      drain();
      // tight tolerances, high gains, low limits
      write_all(31'd4000000, 31'd1, 31'd4, 31'hFFFF, 31'hFFFF, 31'd100, 31'd50, 31'd30);
      repeat (6) fly_mission(3);
      drain();
   endtask

   task automatic test_pressure();
      // receiver holds off while the sender keeps offering
      quiet_run = 1'b1;
      hold_req  = 1'b1;
      repeat (12) send_word(noise_word());
      quiet_run = 1'b0;
      drain();
   endtask

   task automatic test_random_missions(int budget, bit quiet);
      int sent;
      quiet_run = quiet;
      sent = words_in;
      while (words_in - sent < budget) begin
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 6)) send_word(noise_word());
         else
            fly_mission($urandom_range(2, 6));
      end
      quiet_run = 1'b0;
      drain();
   endtask

   task automatic test_random_settings(int rounds);
      for (int k = 0; k < rounds; k++) begin
         write_all(31'($urandom_range(32'h7FFF_FFFF)), 31'($urandom_range(20000)),
                   31'($urandom_range(6000)), 31'($urandom_range(16'hFFFF)),
                   31'($urandom_range(16'hFFFF)), 31'($urandom), 31'($urandom),
                   31'($urandom));
         test_random_missions(150, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      load_defaults();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_random_missions(300, 1'b0);
      test_pressure();
      test_random_missions(200, 1'b1);
      test_config_extremes();
      test_random_settings(6);
      // back to the reset values for a last stretch
      write_all(31'd113377, 31'd3932, 31'd2086, 31'd6554, 31'd2048,
                31'd1229, 31'd1229, 31'd819);
      test_random_missions(200, 1'b0);

      repeat (SETTLE_LEN) @(posedge clock);
      $display("covered %0d words in, %0d results out, %0d aborted, %0d completed missions",
               words_in, words_out, aborts_seen, dones_seen);
      $display("register sweeps at reset values, zeros, maxima and random settings");
      if (err_count == 0 && cmd_expect_q.size() == 0)
         $display("tb_point_approach_motion_controller_top OK");
      else
         $display("tb_point_approach_motion_controller_top NOT OK");
      $finish;
   end

endmodule
